// ===== src/fpfa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpfa_pkg
// types, codes and defaults shared by the partition allocator modules
// ---------------------------------------------------------------------------
package fpfa_pkg;

	// defaults for the top-level parameters
	localparam int MAX_PARTS_DEF  = 128;
	localparam int SIZE_WIDTH_DEF = 16;

	// fixed field widths
	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 7;
	localparam int FIELD_W = 16;
	localparam int MODE_W  = 2;
	localparam int COUNT_W = 8;

	// configuration port
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int REG_SEL_W = 1;
	localparam logic [REG_SEL_W-1:0] REG_FIT_MODE   = 1'b0;
	localparam logic [REG_SEL_W-1:0] REG_PART_COUNT = 1'b1;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

	// placement policies
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [SLOT_W-1:0]  part_index_in;
		logic [FIELD_W-1:0] part_size_in;
		logic [FIELD_W-1:0] need;
	} req_t;

	typedef struct packed {
		logic               granted;
		logic [SLOT_W-1:0]  part_index_out;
		logic [FIELD_W-1:0] leftover;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_CLEAR,
		OP_ALLOC
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [SLOT_W-1:0]  slot;
		logic [FIELD_W-1:0] size;
		logic [FIELD_W-1:0] need;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic init_busy;
	} bstat_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_DONE
	} back_state_t;

endpackage

// ===== src/fixed_partition_fit_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_partition_fit_allocator
// fixed-partition allocator with first, best and worst fit placement
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_data   (fpfa_pkg::req_t)
//  rsp       out        rsp_valid/rsp_stall   rsp_data   (fpfa_pkg::rsp_t)
//  apb       in         psel/penable/pready   fit_mode, part_count
//
//  a load is written directly from the idle state, a clear-all sweeps all MAX_PARTS used flags
//  an allocation request scans min(part_count, MAX_PARTS) entries:
//    the size and used tables are read one entry per cycle, each through its own read port
//  after reset the used flags are swept clear; req_stall
//    stays high for that whole pass
//  the two-entry queue keeps taking requests while the back end works, until it is
//    full; a held result only blocks the back end when the next request result is ready
//
module fixed_partition_fit_allocator #(
	parameter int MAX_PARTS  = fpfa_pkg::MAX_PARTS_DEF,
	parameter int SIZE_WIDTH = fpfa_pkg::SIZE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  fpfa_pkg::req_t                req_data,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output fpfa_pkg::rsp_t                rsp_data,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fpfa_pkg::APB_AW-1:0]   paddr,
	input  logic [fpfa_pkg::APB_DW-1:0]   pwdata,
	output logic [fpfa_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import fpfa_pkg::*;

	// configuration registers
	logic [MODE_W-1:0]    fit_mode_q;
	logic [COUNT_W-1:0]   part_count_q;
	logic                 cfg_wr;
	logic [REG_SEL_W-1:0] reg_sel;

	// front to queue
	logic   push;
	qent_t  push_data;
	qstat_t qstat;

	// queue to back
	qent_t  head;
	logic   head_valid;
	logic   pop;
	bstat_t bstat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	// registers sit on 4-byte boundaries
	assign reg_sel = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= MODE_FIRST;
			part_count_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_FIT_MODE:   fit_mode_q   <= pwdata[MODE_W-1:0];
				REG_PART_COUNT: part_count_q <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back is plain zero-extended register contents
	always_comb begin
		case (reg_sel)
			REG_FIT_MODE:   prdata = APB_DW'(fit_mode_q);
			REG_PART_COUNT: prdata = APB_DW'(part_count_q);
			default:        prdata = '0;
		endcase
	end

	// front: handshake and decode; drops unknown kinds and out-of-range loads
	fpfa_front #(
		.MAX_PARTS (MAX_PARTS)
	) u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.qstat     (qstat),
		.bstat     (bstat),
		.push      (push),
		.push_data (push_data)
	);

	// decouples intake from the table scan
	fpfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.qstat      (qstat)
	);

	// back: table updates, fit scan and the result register
	fpfa_back #(
		.MAX_PARTS  (MAX_PARTS),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.fit_mode   (fit_mode_q),
		.part_count (part_count_q),
		.status     (bstat),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data)
	);

endmodule

// ===== src/fpfa_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpfa_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module fpfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/fpfa_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpfa_front
// request intake: handshake, kind decode and filtering into the queue
// ---------------------------------------------------------------------------
module fpfa_front #(
	parameter int MAX_PARTS = 128
) (
	input  logic           req_valid,
	output logic           req_stall,
	input  fpfa_pkg::req_t req_data,
	input  fpfa_pkg::qstat_t qstat,
	input  fpfa_pkg::bstat_t bstat,
	output logic           push,
	output fpfa_pkg::qent_t push_data
);
	import fpfa_pkg::*;

	logic accept;
	logic keep;
	op_t  op;

	assign req_stall = qstat.full | bstat.init_busy;
	assign accept    = req_valid & ~req_stall;

	// unknown kinds and loads past the table end are dropped here
	always_comb begin
		keep = 1'b0;
		op   = OP_LOAD;
		case (req_data.kind)
			KIND_LOAD: begin
				op   = OP_LOAD;
				keep = (32'(req_data.part_index_in) < 32'(MAX_PARTS));
			end
			KIND_CLEAR: begin
				op   = OP_CLEAR;
				keep = 1'b1;
			end
			KIND_ALLOC: begin
				op   = OP_ALLOC;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push           = accept & keep;
	assign push_data.op   = op;
	assign push_data.slot = req_data.part_index_in;
	assign push_data.size = req_data.part_size_in;
	assign push_data.need = req_data.need;

endmodule

// ===== src/fpfa_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpfa_queue
// short fifo of decoded requests between front and back
// ---------------------------------------------------------------------------
module fpfa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpfa_pkg::qent_t push_data,
	input  logic            pop,
	output fpfa_pkg::qent_t head,
	output logic            head_valid,
	output fpfa_pkg::qstat_t qstat
);
	import fpfa_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qent_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_valid  = ~qstat.empty;
	assign head        = entry_q[rd_ptr_q];

	assign do_push = push & ~qstat.full;
	assign do_pop  = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/fpfa_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpfa_back
// executes queued requests against the partition tables and holds the result
// ---------------------------------------------------------------------------
module fpfa_back #(
	parameter int MAX_PARTS  = 128,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fpfa_pkg::qent_t                 head,
	input  logic                            head_valid,
	output logic                            pop,
	input  logic [fpfa_pkg::MODE_W-1:0]     fit_mode,
	input  logic [fpfa_pkg::COUNT_W-1:0]    part_count,
	output fpfa_pkg::bstat_t                status,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output fpfa_pkg::rsp_t                  rsp_data
);
	import fpfa_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARTS);
	localparam int CNT_W = $clog2(MAX_PARTS + 1);

	back_state_t         state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [CNT_W-1:0]    limit_q, limit_d;
	logic [SIZE_WIDTH-1:0] need_q, need_d;
	logic                found_q;
	logic [IDX_W-1:0]    pick_q;
	logic [SIZE_WIDTH-1:0] best_q;
	logic                eval_s1;
	logic [IDX_W-1:0]    eval_idx_s1;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	rsp_t                rsp_d;

	logic                rd_en;
	logic                size_we;
	logic                used_we;
	logic [IDX_W-1:0]    used_waddr;
	logic                used_wdata;
	logic [SIZE_WIDTH-1:0] size_rdata;
	logic                used_rdata;
	logic                start_scan;
	logic                load_rsp;
	logic                take;
	logic [31:0]         lim32;

	// part_count above the table depth is clipped
	assign lim32 = (32'(part_count) > 32'(MAX_PARTS)) ? 32'(MAX_PARTS) : 32'(part_count);

	fpfa_ram #(
		.WIDTH (SIZE_WIDTH),
		.DEPTH (MAX_PARTS)
	) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (IDX_W'(head.slot)),
		.wdata (SIZE_WIDTH'(head.size)),
		.re    (rd_en),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (size_rdata)
	);

	fpfa_ram #(
		.WIDTH (1),
		.DEPTH (MAX_PARTS)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.re    (rd_en),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (used_rdata)
	);

	// compare stage: free, large enough, and better than the current pick
	assign take = eval_s1 & ~used_rdata & (need_q <= size_rdata) &
		(~found_q |
		 ((fit_mode == MODE_BEST) & (size_rdata < best_q)) |
		 ((fit_mode == MODE_WORST) & (size_rdata > best_q)));

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		limit_d    = limit_q;
		need_d     = need_q;
		pop        = 1'b0;
		rd_en      = 1'b0;
		size_we    = 1'b0;
		used_we    = 1'b0;
		used_waddr = cnt_q[IDX_W-1:0];
		used_wdata = 1'b0;
		start_scan = 1'b0;
		load_rsp   = 1'b0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				used_we = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAX_PARTS - 1)) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					case (head.op)
						OP_LOAD: begin
							size_we    = 1'b1;
							used_we    = 1'b1;
							used_waddr = IDX_W'(head.slot);
						end
						OP_CLEAR: begin
							cnt_d   = '0;
							state_d = ST_CLEAR;
						end
						OP_ALLOC: begin
							need_d     = SIZE_WIDTH'(head.need);
							limit_d    = CNT_W'(lim32);
							cnt_d      = '0;
							start_scan = 1'b1;
							state_d    = ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (cnt_q != limit_q) begin
					rd_en = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					if (found_q) begin
						used_we    = 1'b1;
						used_waddr = pick_q;
						used_wdata = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_d.granted        = found_q;
		rsp_d.part_index_out = found_q ? SLOT_W'(pick_q) : '0;
		rsp_d.leftover       = found_q ? FIELD_W'(best_q - need_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			eval_s1     <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			eval_s1 <= rd_en;
			if (start_scan) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		limit_q     <= limit_d;
		need_q      <= need_d;
		eval_idx_s1 <= cnt_q[IDX_W-1:0];
		if (take) begin
			pick_q <= eval_idx_s1;
			best_q <= size_rdata;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign status.init_busy = (state_q == ST_INIT);
	assign rsp_valid        = rsp_valid_q;
	assign rsp_data         = rsp_q;

endmodule

// ===== src/fpfa_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpfa_checker
// port-level checks on the allocator result channel and configuration port
// ---------------------------------------------------------------------------
module fpfa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pready,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input fpfa_pkg::rsp_t rsp_data
);
	import fpfa_pkg::*;

	// a held result keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// a refusal carries no slot and no leftover
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.granted |->
			rsp_data.part_index_out == '0 && rsp_data.leftover == '0)
		else $error("refused result with nonzero fields");

	// the configuration port never inserts wait states
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

// ===== tb/fpfa_grant_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpfa_grant_checker
// watches the request, result and configuration traffic of the partition
// allocator, keeps its own copy of the partition table and compares every
// result with the placement it predicts
// ---------------------------------------------------------------------------
module fpfa_grant_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  fpfa_pkg::req_t              req_data,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  fpfa_pkg::rsp_t              rsp_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [fpfa_pkg::APB_AW-1:0] paddr,
	input  logic [fpfa_pkg::APB_DW-1:0] pwdata,
	output int                          mismatches,
	output int                          pending
);
	import fpfa_pkg::*;

	logic [FIELD_W-1:0] size_tab [MAX_PARTS_DEF];
	logic               used_tab [MAX_PARTS_DEF];
	logic [MODE_W-1:0]  mode_reg;
	logic [COUNT_W-1:0] count_reg;
	rsp_t               grant_q [$];

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("checker: %s", what);
	endtask

	// scan the active partitions and mark the chosen one used
	function automatic rsp_t place_request(input logic [FIELD_W-1:0] want);
		int   limit;
		int   pick;
		bit   found;
		logic [FIELD_W-1:0] pick_size;
		rsp_t res;
		limit = (count_reg > MAX_PARTS_DEF) ? MAX_PARTS_DEF : int'(count_reg);
		found = 1'b0;
		pick = 0;
		pick_size = '0;
		for (int k = 0; k < limit; k++) begin
			if (!used_tab[k] && want <= size_tab[k]) begin
				if (!found) begin
					found = 1'b1;
					pick = k;
					pick_size = size_tab[k];
					if (mode_reg != MODE_BEST && mode_reg != MODE_WORST)
						break;
				end else if (mode_reg == MODE_BEST && size_tab[k] < pick_size) begin
					pick = k;
					pick_size = size_tab[k];
				end else if (mode_reg == MODE_WORST && size_tab[k] > pick_size) begin
					pick = k;
					pick_size = size_tab[k];
				end
			end
		end
		res = '0;
		if (found) begin
			used_tab[pick] = 1'b1;
			res.granted = 1'b1;
			res.part_index_out = SLOT_W'(pick);
			res.leftover = pick_size - want;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PARTS_DEF; k++) begin
				size_tab[k] = '0;
				used_tab[k] = 1'b0;
			end
			mode_reg = MODE_FIRST;
			count_reg = '0;
			grant_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[APB_AW-1:2] == REG_FIT_MODE)
					mode_reg = pwdata[MODE_W-1:0];
				else if (paddr[APB_AW-1:2] == REG_PART_COUNT)
					count_reg = pwdata[COUNT_W-1:0];
			end
			if (rsp_valid && !rsp_stall) begin
				if (grant_q.size() == 0) begin
					report("result with no request waiting");
				end else begin
					rsp_t want;
					want = grant_q.pop_front();
					if (rsp_data.granted !== want.granted)
						report($sformatf("granted %b, predicted %b",
							rsp_data.granted, want.granted));
					if (rsp_data.part_index_out !== want.part_index_out)
						report($sformatf("slot %0d, predicted %0d",
							rsp_data.part_index_out, want.part_index_out));
					if (rsp_data.leftover !== want.leftover)
						report($sformatf("leftover %0d, predicted %0d",
							rsp_data.leftover, want.leftover));
				end
			end
			if (req_valid && !req_stall) begin
				case (req_data.kind)
					KIND_LOAD: begin
						size_tab[req_data.part_index_in] = req_data.part_size_in;
						used_tab[req_data.part_index_in] = 1'b0;
					end
					KIND_CLEAR: begin
						for (int k = 0; k < MAX_PARTS_DEF; k++)
							used_tab[k] = 1'b0;
					end
					KIND_ALLOC: grant_q.push_back(place_request(req_data.need));
					default: ;
				endcase
			end
			pending = grant_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the fixed-partition fit allocator
// ---------------------------------------------------------------------------
// a short directed run walks every placement policy, refusals, the zero
// count and ignored kinds on a five-slot table; then the whole table is
// loaded and random phases follow, each with a policy, a partition count
// and an idle and stall profile; a side checker predicts and compares results
// ---------------------------------------------------------------------------
module tb;
	import fpfa_pkg::*;

	// codes the package leaves unnamed
	localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam int CYCLE_LIMIT = 1_500_000;
	// covers a full scan plus two clear-all passes still queued
	localparam int SETTLE      = 3 * MAX_PARTS_DEF + 20;
	localparam int RAND_PHASES = 16;
	localparam int PHASE_ITEMS = 104;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	req_t               req_data;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	int   mismatches;
	int   pending;
	int   cycles = 0;
	int   idle_pct;
	int   stall_pct;
	logic req_taken = 1'b0;
	logic apb_done = 1'b0;

	// per-phase plans: counts mix tiny tables with the clamped extremes
	int count_plan [RAND_PHASES] = '{2, 128, 1, 5, 255, 3, 8, 16,
		0, 4, 12, 200, 6, 24, 32, 10};
	logic [MODE_W-1:0] mode_plan [4] = '{MODE_FIRST, MODE_BEST, MODE_WORST,
		MODE_SPARE};
	int idle_plan  [4] = '{0, 57, 0, 8};
	int stall_plan [4] = '{0, 0, 57, 8};

	fixed_partition_fit_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	fpfa_grant_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// handshakes seen at the rising edge, read back at the falling edge
	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
		apb_done  <= psel && penable && pready;
	end

	// result side stalls at random in the current profile
	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < stall_pct);

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// mostly small sizes so that requests both fit and miss
	function automatic int rand_size();
		case ($urandom_range(7))
			0: return 0;
			1: return 16'hFFFF;
			2, 3: return $urandom_range(16'hFFFF);
			default: return $urandom_range(1000);
		endcase
	endfunction

	function automatic int rand_need();
		case ($urandom_range(7))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(16'hFFFF);
			default: return $urandom_range(1200);
		endcase
	endfunction

	// one request, fields it does not use are random; called at a falling edge
	task automatic send_item(input logic [KIND_W-1:0] kind, input int slot,
		input int size, input int want);
		req_t r;
		r.kind = kind;
		r.part_index_in = (slot < 0) ? SLOT_W'($urandom) : SLOT_W'(slot);
		r.part_size_in = (size < 0) ? FIELD_W'($urandom) : FIELD_W'(size);
		r.need = (want < 0) ? FIELD_W'($urandom) : FIELD_W'(want);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(negedge clk); while (!req_taken);
	endtask

	task automatic write_reg(input logic [REG_SEL_W-1:0] idx, input int value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!apb_done);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// let every result arrive and the back end finish queued loads and clears
	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_config(input logic [MODE_W-1:0] mode, input int count);
		drain();
		write_reg(REG_FIT_MODE, mode);
		write_reg(REG_PART_COUNT, count);
	endtask

	initial begin
		int n;
		int roll;
		int eff;
		int slot;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero count refuses everything, unknown kind is dropped
		set_config(MODE_FIRST, 0);
		send_item(KIND_ALLOC, -1, -1, 0);
		send_item(KIND_NOP, -1, -1, -1);
		send_item(KIND_LOAD, 0, 0, -1);
		send_item(KIND_LOAD, 1, 16'hFFFF, -1);
		send_item(KIND_LOAD, 2, 300, -1);
		send_item(KIND_LOAD, 3, 300, -1);
		send_item(KIND_LOAD, 4, 100, -1);

		// first fit down the table until nothing is left
		set_config(MODE_FIRST, 5);
		send_item(KIND_ALLOC, -1, -1, 0);
		send_item(KIND_ALLOC, -1, -1, 16'hFFFF);
		send_item(KIND_ALLOC, -1, -1, 150);
		send_item(KIND_ALLOC, -1, -1, 150);
		send_item(KIND_ALLOC, -1, -1, 150);
		send_item(KIND_CLEAR, -1, -1, -1);

		// best fit: exact fit, then a tie between equal partitions
		set_config(MODE_BEST, 5);
		send_item(KIND_ALLOC, -1, -1, 100);
		send_item(KIND_ALLOC, -1, -1, 200);
		send_item(KIND_LOAD, 4, 100, -1);

		// worst fit walks from the largest down, then refuses
		set_config(MODE_WORST, 5);
		send_item(KIND_ALLOC, -1, -1, 1);
		send_item(KIND_ALLOC, -1, -1, 1);
		send_item(KIND_ALLOC, -1, -1, 1);
		send_item(KIND_ALLOC, -1, -1, 1);
		send_item(KIND_CLEAR, -1, -1, -1);

		// unknown policy behaves as first fit
		set_config(MODE_SPARE, 5);
		send_item(KIND_ALLOC, -1, -1, 0);
		send_item(KIND_ALLOC, -1, -1, 0);

		// load the whole table so any count can be scanned from here on
		idle_pct = idle_plan[3];
		stall_pct = stall_plan[3];
		for (int s = 0; s < MAX_PARTS_DEF; s++)
			send_item(KIND_LOAD, s, rand_size(), -1);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_config(mode_plan[ph % 4], count_plan[ph]);
			idle_pct = idle_plan[(ph / 4) % 4];
			stall_pct = stall_plan[(ph / 4) % 4];
			eff = (count_plan[ph] > MAX_PARTS_DEF) ? MAX_PARTS_DEF : count_plan[ph];
			n = 0;
			while (n < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 55) begin
					send_item(KIND_ALLOC, -1, -1, rand_need());
					n++;
				end else if (roll < 80) begin
					// mostly reload slots in use so partitions come free again
					if (eff > 0 && $urandom_range(3) != 0)
						slot = $urandom_range(eff - 1);
					else
						slot = $urandom_range(MAX_PARTS_DEF - 1);
					send_item(KIND_LOAD, slot, rand_size(), -1);
					n++;
				end else if (roll < 88) begin
					send_item(KIND_CLEAR, -1, -1, -1);
					n++;
				end else begin
					// ignored by the block
					send_item(KIND_NOP, -1, -1, -1);
					n++;
				end
			end
		end

		drain();
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/fpfa_pkg.sv
src/fpfa_ram.sv
src/fpfa_front.sv
src/fpfa_queue.sv
src/fpfa_back.sv
src/fixed_partition_fit_allocator.sv
src/fpfa_checker.sv
tb/fpfa_grant_checker.sv
tb/tb.sv
